// ----- hdl/htd_pkg.sv -----
// constants and widths for the hash thread dispatch block
// fnv-1a parameters, field widths and pipeline partitioning; no dependencies
package htd_pkg;

  localparam int unsigned VT_WIDTH = 32;  // virtual thread id
  localparam int unsigned WC_WIDTH = 11;  // worker count register
  localparam int unsigned WI_WIDTH = 10;  // worker index result

  localparam int unsigned S_TDATA_WIDTH = 32;
  localparam int unsigned M_TDATA_WIDTH = 16;

  localparam logic [VT_WIDTH-1:0] FNV_BASIS = 32'd2166136261;
  localparam logic [VT_WIDTH-1:0] FNV_PRIME = 32'd16777619;
  localparam int unsigned BYTE_WIDTH = 8;

  localparam int unsigned MAX_WORKERS_DEF = 1024;

  // one byte folded in per hash stage, four remainder bits per divide stage
  localparam int unsigned HASH_STAGES   = VT_WIDTH / BYTE_WIDTH;
  localparam int unsigned DIV_BITS      = 4;
  localparam int unsigned DIV_STAGES    = VT_WIDTH / DIV_BITS;
  localparam int unsigned NUM_STAGES    = HASH_STAGES + DIV_STAGES;

endpackage

// ----- hdl/hash_thread_dispatch_unit.sv -----
// hash thread dispatch: fnv-1a 32-bit hash of a thread id, modulo worker count
// depends on htd_pkg for constants and widths
//
// usage:
//   slave stream (s_axis_*) carries one 32-bit virtual thread id per word.
//   master stream (m_axis_*) returns one worker index per input word, in order.
//   cfg_we_i / cfg_wdata_i load the worker count; write it only while the
//   pipeline is empty. zero is taken as one, values above MAX_WORKERS are
//   clamped to MAX_WORKERS.
// stages: an accepted input word passes 4 hash stages, one 32x32
//   multiply each, then 8 remainder stages of 4 compare-subtract steps each,
//   on its way to m_axis.
// throughput: one word per cycle while m_axis is not stalled; every stage is a register with a valid bit.
// stall: each stage holds while the stage after it is full and not moving,
//   so bubbles are squeezed out and the input keeps being taken until the
//   pipeline is full; nothing is dropped or repeated.
// reset: all valid bits clear, worker count returns to one.
module hash_thread_dispatch_unit
  import htd_pkg::*;
#(
  parameter int unsigned MAX_WORKERS = MAX_WORKERS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // configuration: worker count
  input  logic                     cfg_we_i,
  input  logic [WC_WIDTH-1:0]      cfg_wdata_i,
  // input stream
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [S_TDATA_WIDTH-1:0] s_axis_tdata,   // [31:0] virtual_thread
  // output stream
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [M_TDATA_WIDTH-1:0] m_axis_tdata    // [9:0] worker_index, [15:10] zero
);

  localparam logic [31:0]         MaxWorkers32 = 32'(MAX_WORKERS);
  localparam logic [WC_WIDTH-1:0] MaxWorkersWc = WC_WIDTH'(MAX_WORKERS);

  // effective divisor, already clamped to 1..MAX_WORKERS
  logic [WC_WIDTH-1:0] div_d, div_q;

  // per-stage valid bits and handshake
  logic [NUM_STAGES-1:0] vld_q;
  logic [NUM_STAGES-1:0] rdy;

  // hash stages: running hash; later stages reuse it as the shifting dividend
  logic [VT_WIDTH-1:0] hash_q [NUM_STAGES-1];
  // thread id bytes still to be folded in
  logic [VT_WIDTH-1:0] vt_q   [HASH_STAGES-1];
  // partial remainder in the divide stages
  logic [WC_WIDTH-1:0] rem_q  [DIV_STAGES];

  // -------------------------------------------------------------------------
  // worker count register
  // -------------------------------------------------------------------------
  always_comb begin
    div_d = div_q;
    if (cfg_we_i) begin
      if (cfg_wdata_i == '0) begin
        div_d = WC_WIDTH'(1);
      end else if (32'(cfg_wdata_i) > MaxWorkers32) begin
        div_d = MaxWorkersWc;
      end else begin
        div_d = cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_q <= WC_WIDTH'(1);
    end else begin
      div_q <= div_d;
    end
  end

  // -------------------------------------------------------------------------
  // ready chain: a stage moves when it is empty or the next one moves
  // -------------------------------------------------------------------------
  always_comb begin
    rdy[NUM_STAGES-1] = !vld_q[NUM_STAGES-1] || m_axis_tready;
    for (int s = NUM_STAGES - 2; s >= 0; s--) begin
      rdy[s] = !vld_q[s] || rdy[s+1];
    end
  end

  assign s_axis_tready = rdy[0];

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) begin
        vld_q[0] <= s_axis_tvalid;
      end
      for (int s = 1; s < NUM_STAGES; s++) begin
        if (rdy[s]) begin
          vld_q[s] <= vld_q[s-1];
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // datapath stages
  // -------------------------------------------------------------------------
  for (genvar s = 0; s < NUM_STAGES; s++) begin : g_stage
    logic load;

    if (s == 0) begin : g_load_first
      assign load = rdy[s] && s_axis_tvalid;
    end else begin : g_load_rest
      assign load = rdy[s] && vld_q[s-1];
    end

    if (s < HASH_STAGES) begin : g_hash
      // xor in byte s, then multiply by the prime, modulo 2^32
      logic [VT_WIDTH-1:0] h_in, vt_in, h_next;

      if (s == 0) begin : g_src_in
        assign h_in  = FNV_BASIS;
        assign vt_in = s_axis_tdata[VT_WIDTH-1:0];
      end else begin : g_src_prev
        assign h_in  = hash_q[s-1];
        assign vt_in = vt_q[s-1];
      end

      assign h_next = VT_WIDTH'((h_in ^ VT_WIDTH'(vt_in[s*BYTE_WIDTH +: BYTE_WIDTH]))
                                * FNV_PRIME);

      always_ff @(posedge clk_i) begin
        if (load) begin
          hash_q[s] <= h_next;
        end
      end

      if (s < HASH_STAGES - 1) begin : g_vt
        always_ff @(posedge clk_i) begin
          if (load) begin
            vt_q[s] <= vt_in;
          end
        end
      end
    end else begin : g_div
      // restoring remainder, DIV_BITS dividend bits per stage, msb first
      logic [WC_WIDTH-1:0] r_in, r_out;
      logic [VT_WIDTH-1:0] dvd_out;

      if (s == HASH_STAGES) begin : g_rem_first
        assign r_in = '0;
      end else begin : g_rem_prev
        assign r_in = rem_q[s-HASH_STAGES-1];
      end

      always_comb begin
        logic [WC_WIDTH:0]   r_w;
        logic [WC_WIDTH-1:0] r;
        logic [VT_WIDTH-1:0] dvd;
        r   = r_in;
        dvd = hash_q[s-1];
        for (int j = 0; j < DIV_BITS; j++) begin
          r_w = {r, dvd[VT_WIDTH-1]};
          dvd = {dvd[VT_WIDTH-2:0], 1'b0};
          if (r_w >= {1'b0, div_q}) begin
            r_w = r_w - {1'b0, div_q};
          end
          r = r_w[WC_WIDTH-1:0];
        end
        r_out   = r;
        dvd_out = dvd;
      end

      always_ff @(posedge clk_i) begin
        if (load) begin
          rem_q[s-HASH_STAGES] <= r_out;
        end
      end

      if (s < NUM_STAGES - 1) begin : g_dvd
        always_ff @(posedge clk_i) begin
          if (load) begin
            hash_q[s] <= dvd_out;
          end
        end
      end
    end
  end

  assign m_axis_tvalid = vld_q[NUM_STAGES-1];
  assign m_axis_tdata  = {(M_TDATA_WIDTH - WI_WIDTH)'(0),
                          rem_q[DIV_STAGES-1][WI_WIDTH-1:0]};

  // -------------------------------------------------------------------------
  // assertions
  // -------------------------------------------------------------------------
  a_div_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_q != '0)
    else $error("worker count divisor is zero");

  a_rem_below_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[NUM_STAGES-1] |-> (rem_q[DIV_STAGES-1] < div_q))
    else $error("result not below worker count");

  a_accept_fills : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> vld_q[0])
    else $error("accepted word missing from first stage");

  a_empty_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !vld_q[0] |-> s_axis_tready)
    else $error("empty first stage refuses input");

endmodule

// ----- sim/htd_dispatch_checker.sv -----
// checker for the hash thread dispatch block: watches the config port and both streams
// predicts each worker index from the accepted thread id and compares in order
// depends on htd_pkg for widths and fnv-1a constants
module htd_dispatch_checker
  import htd_pkg::*;
#(
  parameter int unsigned MAX_WORKERS = MAX_WORKERS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [WC_WIDTH-1:0]      cfg_wdata_i,
  input  logic                     in_valid_i,
  input  logic                     in_ready_i,
  input  logic [S_TDATA_WIDTH-1:0] in_data_i,
  input  logic                     out_valid_i,
  input  logic                     out_ready_i,
  input  logic [M_TDATA_WIDTH-1:0] out_data_i,
  output int                       mismatches_o,
  output int                       pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned REPORT_LIMIT = 100;

  logic [WC_WIDTH-1:0] worker_count;
  logic [WI_WIDTH-1:0] expected_slots[$];

  function automatic logic [VT_WIDTH-1:0] fnv1a_hash(input logic [VT_WIDTH-1:0] vt_id);
    logic [VT_WIDTH-1:0] h;
    h = FNV_BASIS;
    for (int k = 0; k < HASH_STAGES; k++) begin
      h = h ^ {{(VT_WIDTH-BYTE_WIDTH){1'b0}}, vt_id[BYTE_WIDTH*k +: BYTE_WIDTH]};
      h = h * FNV_PRIME;
    end
    return h;
  endfunction

  function automatic logic [WI_WIDTH-1:0] predict_worker(input logic [VT_WIDTH-1:0] vt_id,
                                                         input logic [WC_WIDTH-1:0] count);
    logic [VT_WIDTH-1:0] divisor;
    logic [VT_WIDTH-1:0] rem;
    // zero acts as one, anything past the limit is clamped
    divisor = VT_WIDTH'(count);
    if (divisor == 0) divisor = 1;
    if (divisor > MAX_WORKERS) divisor = VT_WIDTH'(MAX_WORKERS);
    rem = fnv1a_hash(vt_id) % divisor;
    return rem[WI_WIDTH-1:0];
  endfunction

  function automatic void report(input string field, input int unsigned want,
                                 input int unsigned got);
    if (mismatches_o < REPORT_LIMIT)
      $error("%s mismatch: expected %0d, actual %0d", field, want, got);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [WI_WIDTH-1:0] want;
    int errs;
    if (!rst_ni) begin
      worker_count <= WC_WIDTH'(1);
      expected_slots.delete();
      mismatches_o <= 0;
      pending_o <= 0;
    end else begin
      errs = mismatches_o;
      if (cfg_we_i) worker_count <= cfg_wdata_i;
      if (in_valid_i && in_ready_i)
        expected_slots.push_back(predict_worker(in_data_i[VT_WIDTH-1:0], worker_count));
      if (out_valid_i && out_ready_i) begin
        if (expected_slots.size() == 0) begin
          if (errs < REPORT_LIMIT)
            $error("worker_index mismatch: no word expected, actual %0d",
                   out_data_i[WI_WIDTH-1:0]);
          errs++;
        end else begin
          want = expected_slots.pop_front();
          if (out_data_i[WI_WIDTH-1:0] !== want) begin
            report("worker_index", 32'(want), 32'(out_data_i[WI_WIDTH-1:0]));
            errs++;
          end
          // bits above the index must read zero
          if (out_data_i[M_TDATA_WIDTH-1:WI_WIDTH] !== '0) begin
            report("tdata padding", 0, 32'(out_data_i[M_TDATA_WIDTH-1:WI_WIDTH]));
            errs++;
          end
        end
      end
      mismatches_o <= errs;
      pending_o <= expected_slots.size();
    end
  end

endmodule

// ----- sim/testbench.sv -----
// top of the hash thread dispatch regression: clock, reset, stimulus and verdict
// instantiates hash_thread_dispatch_unit and htd_dispatch_checker; depends on htd_pkg
module testbench;
  import htd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_CYCLES = NUM_STAGES + 8;  // pipeline depth plus slack
  localparam int HOLD_CYCLES  = 120;             // long receiver hold-off
  localparam int HOLD_WORDS   = 80;              // words offered during the hold-off

  logic                     clk_i;
  logic                     rst_ni;
  logic                     cfg_we_i;
  logic [WC_WIDTH-1:0]      cfg_wdata_i;
  logic                     s_axis_tvalid;
  logic                     s_axis_tready;
  logic [S_TDATA_WIDTH-1:0] s_axis_tdata;   // [31:0] virtual_thread
  logic                     m_axis_tvalid;
  logic                     m_axis_tready;
  logic [M_TDATA_WIDTH-1:0] m_axis_tdata;   // [9:0] worker_index, [15:10] zero

  int mismatches;
  int pending;
  int hold_requests = 0;  // bumped by the sender side
  int holds_served  = 0;  // bumped by the receiver side

  // 10 ns clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  hash_thread_dispatch_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  htd_dispatch_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_i   (s_axis_tready),
    .in_data_i    (s_axis_tdata),
    .out_valid_i  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_i   (m_axis_tdata),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  // thread ids biased toward byte edges: all-zero and all-one lanes, small and single-bit values
  function automatic logic [VT_WIDTH-1:0] random_vt_id();
    logic [VT_WIDTH-1:0] id;
    case ($urandom_range(0, 7))
      4: begin
        for (int k = 0; k < HASH_STAGES; k++) begin
          case ($urandom_range(0, 2))
            0: id[BYTE_WIDTH*k +: BYTE_WIDTH] = '0;
            1: id[BYTE_WIDTH*k +: BYTE_WIDTH] = '1;
            default: id[BYTE_WIDTH*k +: BYTE_WIDTH] = BYTE_WIDTH'($urandom());
          endcase
        end
      end
      5: id = VT_WIDTH'($urandom_range(0, 1023));
      6: id = ~VT_WIDTH'($urandom_range(0, 1023));
      7: id = VT_WIDTH'(1) << $urandom_range(0, VT_WIDTH - 1);
      default: id = $urandom();
    endcase
    return id;
  endfunction

  // offer one word and hold it until taken; valid stays up for the next word
  task automatic send_vt_id(input logic [VT_WIDTH-1:0] vt_id);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= vt_id;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // sender gap with junk on the data lines
  task automatic idle_sender(input int cycles);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= $urandom();
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  // stop offering and wait until every predicted index has come back
  task automatic wait_pipeline_empty();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
  endtask

  // worker count is only touched with the pipeline empty and settled
  task automatic load_worker_count(input logic [WC_WIDTH-1:0] count);
    wait_pipeline_empty();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= count;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= WC_WIDTH'($urandom());
  endtask

  // random words in bursts; optionally start with a back-to-back run against a stalled receiver
  task automatic run_batch(input int n_words, input bit long_hold, input bit mid_drain);
    int sent;
    int burst;
    sent = 0;
    if (long_hold) begin
      hold_requests++;
      repeat (HOLD_WORDS) send_vt_id(random_vt_id());
      sent = HOLD_WORDS;
    end
    while (sent < n_words) begin
      burst = $urandom_range(1, 24);
      for (int i = 0; i < burst && sent < n_words; i++) begin
        send_vt_id(random_vt_id());
        sent++;
        // sender pauses until the block has handed back everything
        if (mid_drain && sent == n_words / 2) wait_pipeline_empty();
      end
      if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 9));
    end
  endtask

  // receiver: stretches of different stall patterns, plus long hold-offs on request
  initial begin : receiver
    int stretch;
    int mode;
    int n;
    m_axis_tready = 1'b0;
    forever begin
      if (holds_served != hold_requests) begin
        @(negedge clk_i);
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
        holds_served++;
      end
      stretch = $urandom_range(4, 40);
      mode = $urandom_range(0, 3);
      n = 0;
      while (n < stretch && holds_served == hold_requests) begin
        @(negedge clk_i);
        case (mode)
          0: m_axis_tready <= 1'b1;                         // no stalls
          1: m_axis_tready <= 1'($urandom_range(0, 1));     // coin flip
          2: m_axis_tready <= ($urandom_range(0, 3) == 0);  // mostly stalled
          default: m_axis_tready <= (n % 3 == 2);           // ready when n % 3 == 2
        endcase
        n++;
      end
    end
  end

  // stimulus and verdict
  initial begin : stimulus
    logic [VT_WIDTH-1:0] edge_ids[14];
    logic [WC_WIDTH-1:0] counts[14];
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    edge_ids = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000,
                 32'h0000_00FF, 32'hFF00_0000, 32'h00FF_0000, 32'h0000_FF00,
                 32'h5555_5555, 32'hAAAA_AAAA, 32'h0101_0101, 32'hFEFE_FEFE,
                 32'h7FFF_FFFF, 32'h1234_5678};
    counts = '{11'd1, 11'd2, 11'd3, 11'd5, 11'd7, 11'd16, 11'd100, 11'd255,
               11'd512, 11'd1000, 11'd1023, 11'd1024, 11'd1536, 11'd2047};
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(negedge clk_i);

    // reset count of one: every index is zero
    send_vt_id(32'h0000_0000);
    send_vt_id(32'hFFFF_FFFF);

    // full worker range over the edge ids
    load_worker_count(WC_WIDTH'(1024));
    foreach (edge_ids[i]) send_vt_id(edge_ids[i]);

    // zero count behaves as one
    load_worker_count(WC_WIDTH'(0));
    send_vt_id(32'hFFFF_FFFF);
    send_vt_id(32'h1234_5678);
    send_vt_id(32'hAAAA_AAAA);

    // counts above the limit clamp to it
    load_worker_count(WC_WIDTH'(2047));
    send_vt_id(32'hFFFF_FFFF);
    send_vt_id(32'h5555_5555);
    send_vt_id(32'h0000_0000);
    load_worker_count(WC_WIDTH'(1025));
    send_vt_id(32'h8000_0000);
    send_vt_id(32'h7FFF_FFFF);

    // random phases over a spread of worker counts
    foreach (counts[i]) begin
      load_worker_count(counts[i]);
      run_batch(90, i == 4, i == 9);
    end
    repeat (4) begin
      load_worker_count(WC_WIDTH'($urandom_range(0, 2047)));
      run_batch(90, 1'b0, 1'b0);
    end
    load_worker_count(WC_WIDTH'(0));
    run_batch(40, 1'b0, 1'b0);

    wait_pipeline_empty();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("hash_thread_dispatch_unit regression: pass");
    end else begin
      $display("hash_thread_dispatch_unit regression: fail");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin : watchdog
    #2_000_000;
    $display("hash_thread_dispatch_unit regression: fail");
    $finish;
  end

endmodule
